// ===== rtl/lic_pkg.sv =====
// Shared constants, codes and item types for the latched interrupt controller.
`timescale 1ns / 1ps

package lic_pkg;

   localparam int NUM_LINES = 32;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 5;
   localparam int CMD_W     = 2;
   localparam int MODE_W    = 2;
   localparam int LINE_W    = 5;

   localparam logic [DATA_W-1:0] LINE_MASK = DATA_W'((64'd1 << NUM_LINES) - 64'd1);
   localparam logic [DATA_W-1:0] ALL_ONES  = '1;

   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   localparam logic [MODE_W-1:0] MODE_EDGE      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LEVEL     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LEVEL_CLR = 2'd2;

   localparam logic [ADDR_W-1:0] OFF_STATUS     = 5'h00;
   localparam logic [ADDR_W-1:0] OFF_CLEAR      = 5'h08;
   localparam logic [ADDR_W-1:0] OFF_MASK_STAT  = 5'h0c;
   localparam logic [ADDR_W-1:0] OFF_MASK_SET   = 5'h10;
   localparam logic [ADDR_W-1:0] OFF_MASK_CLR   = 5'h14;
   localparam logic [ADDR_W-1:0] LVL_MASK_STAT  = 5'h04;
   localparam logic [ADDR_W-1:0] LVL_MASK_SET   = 5'h08;
   localparam logic [ADDR_W-1:0] LVL_MASK_CLR   = 5'h0c;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
      logic [DATA_W-1:0] sources;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      logic              irq_out;
      logic [LINE_W-1:0] first_line;
      logic              first_valid;
   } rsp_type;

endpackage

// ===== rtl/lic_ifs.sv =====
// Handshake channel interfaces for request, response and control register items.
`timescale 1ns / 1ps

interface lic_req_if;
   logic                      valid;
   logic                      ready;
   logic [lic_pkg::CMD_W-1:0]  cmd;
   logic [lic_pkg::ADDR_W-1:0] addr;
   logic [lic_pkg::DATA_W-1:0] wdata;
   logic [lic_pkg::DATA_W-1:0] sources;
   modport source (output valid, cmd, addr, wdata, sources, input ready);
   modport sink (input valid, cmd, addr, wdata, sources, output ready);
endinterface

interface lic_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lic_pkg::DATA_W-1:0] rdata;
   logic                      irq_out;
   logic [lic_pkg::LINE_W-1:0] first_line;
   logic                      first_valid;
   modport source (output valid, rdata, irq_out, first_line, first_valid, input ready);
   modport sink (input valid, rdata, irq_out, first_line, first_valid, output ready);
endinterface

interface lic_csr_if;
   logic                      valid;
   logic                      ready;
   logic [lic_pkg::MODE_W-1:0] layout_mode;
   modport source (output valid, layout_mode, input ready);
   modport sink (input valid, layout_mode, output ready);
endinterface

// ===== rtl/lic_pri_enc.sv =====
// Lowest-set-bit priority encoder over the pending interrupt lines.
`timescale 1ns / 1ps

module lic_pri_enc (
   input  logic [lic_pkg::DATA_W-1:0] pend,
   output logic [lic_pkg::LINE_W-1:0] first_line,
   output logic                       first_valid
);
   import lic_pkg::*;

   logic [DATA_W-1:0] lowest;

   assign lowest      = pend & (~pend + DATA_W'(1));
   assign first_valid = |pend;

   always_comb begin
      first_line = '0;
      for (int i = 0; i < DATA_W; i++) begin
         if (lowest[i]) begin
            first_line = first_line | LINE_W'(i);
         end
      end
   end

endmodule

// ===== rtl/lic_core.sv =====
// Status, mask and line history registers with their update and result logic.
`timescale 1ns / 1ps

module lic_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lic_pkg::MODE_W-1:0] mode,
   input  logic                       advance,
   input  lic_pkg::req_type           item,
   output lic_pkg::rsp_type           result
);
   import lic_pkg::*;

   logic [DATA_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0] mask_ff, mask_in;
   logic [DATA_W-1:0] last_ff, last_in;
   logic [DATA_W-1:0] rdata;
   logic [DATA_W-1:0] pend;
   logic [ADDR_W-1:0] off_mask_stat;
   logic [ADDR_W-1:0] off_mask_set;
   logic [ADDR_W-1:0] off_mask_clr;
   logic              is_edge;
   logic              is_lvl;

   assign is_edge       = (mode == MODE_EDGE);
   assign is_lvl        = (mode == MODE_LEVEL);
   assign off_mask_stat = is_lvl ? LVL_MASK_STAT : OFF_MASK_STAT;
   assign off_mask_set  = is_lvl ? LVL_MASK_SET : OFF_MASK_SET;
   assign off_mask_clr  = is_lvl ? LVL_MASK_CLR : OFF_MASK_CLR;

   always_comb begin
      status_in = status_ff;
      mask_in   = mask_ff;
      last_in   = last_ff;
      rdata     = '0;
      case (item.cmd)
         CMD_READ: begin
            if (item.addr == OFF_STATUS) begin
               rdata = status_ff;
            end else if (item.addr == off_mask_stat) begin
               rdata = mask_ff;
            end
         end
         CMD_WRITE: begin
            if (item.addr == off_mask_set) begin
               mask_in = mask_ff | item.wdata;
            end else if (item.addr == off_mask_clr) begin
               mask_in = mask_ff & ~(item.wdata & LINE_MASK);
            end else if (item.addr == OFF_CLEAR && is_edge) begin
               status_in = status_ff & ~item.wdata;
            end
         end
         CMD_TICK: begin
            if (is_edge) begin
               status_in = status_ff | (item.sources & ~last_ff & LINE_MASK);
            end else begin
               status_in = item.sources & LINE_MASK;
            end
            last_in = item.sources;
         end
         default: begin
         end
      endcase
   end

   assign pend = status_in & ~mask_in;

   lic_pri_enc u_pri_enc (
      .pend        (pend),
      .first_line  (result.first_line),
      .first_valid (result.first_valid)
   );

   assign result.rdata   = rdata;
   assign result.irq_out = |pend;

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         mask_ff   <= ALL_ONES;
         last_ff   <= '0;
      end else if (advance) begin
         status_ff <= status_in;
         mask_ff   <= mask_in;
         last_ff   <= last_in;
      end
   end

endmodule

// ===== rtl/latched_interrupt_controller_top.sv =====
// Top level of the 32-line latched interrupt controller.
`timescale 1ns / 1ps
//
//   Channel  Direction  Carries
//   req_bus  in         cmd, addr, wdata, sources
//   rsp_bus  out        rdata, irq_out, first_line, first_valid
//   csr_bus  in         layout_mode
//
// An item passes from the input register into the result register, which offers its
// result on rsp_bus until it is taken; one item is taken per cycle while req_bus.ready
// is high.
// Reset clears the status and line history, masks every line and selects the edge layout.
// A stalled result holds the result register; the input register keeps accepting while
// either stage has room, and req_bus.ready follows rsp_bus.ready when both are full.

module latched_interrupt_controller_top (
   input  logic       clock,
   input  logic       reset,
   lic_req_if.sink    req_bus,
   lic_rsp_if.source  rsp_bus,
   lic_csr_if.sink    csr_bus
);
   import lic_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   req_type           item_ff;
   logic              item_valid_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   rsp_type           result;
   logic              rsp_room;
   logic              advance;
   logic              req_take;

   assign rsp_room = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = item_valid_ff && rsp_room;
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !item_valid_ff || rsp_room;
   assign csr_bus.ready = 1'b1;

   lic_core u_core (
      .clock   (clock),
      .reset   (reset),
      .mode    (mode_ff),
      .advance (advance),
      .item    (item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_EDGE;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            mode_ff <= csr_bus.layout_mode;
         end
         if (req_bus.ready) begin
            item_valid_ff <= req_bus.valid;
         end
         if (rsp_room) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.cmd     <= req_bus.cmd;
         item_ff.addr    <= req_bus.addr;
         item_ff.wdata   <= req_bus.wdata;
         item_ff.sources <= req_bus.sources;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rdata       = rsp_ff.rdata;
   assign rsp_bus.irq_out     = rsp_ff.irq_out;
   assign rsp_bus.first_line  = rsp_ff.first_line;
   assign rsp_bus.first_valid = rsp_ff.first_valid;

endmodule
